>>> rtl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg: shared types and constants of the correlation block
// Widths of the accumulators and the finishing arithmetic, the controller
// states, the operation codes of the shared multiplier and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int MaxSamples = 1024;
  localparam int SampleBits = 16;
  localparam int CountBits  = $clog2(MaxSamples + 1);
  localparam int MinCount   = 2;

  // Accumulators: sum of samples and sums of products.
  localparam int SumW  = SampleBits + CountBits;
  localparam int SqW   = 2 * SampleBits + CountBits - 1;

  // Finishing arithmetic. Every term of the formula is below 2^(MagW-1).
  localparam int MagW     = 2 * SampleBits + 2 * CountBits - 2;
  localparam int WorkW    = MagW + 1;
  localparam int ProdW    = 2 * MagW;
  localparam int FracBits = 15;
  localparam int CoefW    = FracBits + 1;
  localparam int DivShift = 2 * FracBits;
  localparam int QuoBits  = DivShift + 1;
  localparam int LimW     = ProdW + DivShift;
  localparam int SqrtW    = QuoBits + 1;
  localparam int CtrW     = $clog2(QuoBits);

  typedef enum logic [2:0] {
    OP_NXX, // n * Sxx
    OP_SXX, // Sx * Sx
    OP_NYY, // n * Syy
    OP_SYY, // Sy * Sy
    OP_NXY, // n * Sxy
    OP_SXY, // Sx * Sy
    OP_AB,  // A * B
    OP_NN   // N * N
  } op_e;

  typedef enum logic [3:0] {
    S_ACC,
    S_DRAIN,
    S_MLOAD,
    S_MRUN,
    S_CHECK,
    S_DIV,
    S_SINIT,
    S_SQRT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic s1_load;
    logic mul_start;
    logic mul_step;
    logic mul_write;
    op_e  op;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic degen;
  } sts_t;

endpackage

>>> rtl/pcc_datapath.sv
// ----------------------------------------------------------------------------
// pcc_datapath: accumulators and finishing arithmetic
// A product stage and the running sums, a shift-add multiplier shared by
// all products of the formula, a restoring divider and a bitwise integer
// square root, plus the result register.
// ----------------------------------------------------------------------------
module pcc_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [pcc_pkg::SampleBits-1:0] x_sample_i,
  input  logic signed [pcc_pkg::SampleBits-1:0] y_sample_i,
  input  pcc_pkg::cmd_t                       cmd_i,
  output pcc_pkg::sts_t                       sts_o,
  output logic signed [pcc_pkg::CoefW-1:0]    coefficient_o,
  output logic                                degenerate_o,
  output logic                                overflowed_o,
  output logic [pcc_pkg::CountBits-1:0]       pair_count_o
);

  localparam int SB = pcc_pkg::SampleBits;
  localparam int PB = 2 * SB;

  // Product stage.
  logic                 s1_valid_q;
  logic signed [SB-1:0] s1_x_q, s1_y_q;
  logic signed [PB-1:0] s1_xy_q, s1_xx_q, s1_yy_q;

  // Running sums.
  logic [pcc_pkg::CountBits-1:0]     cnt_q;
  logic signed [pcc_pkg::SumW-1:0]   sum_x_q, sum_y_q;
  logic signed [pcc_pkg::SqW-1:0]    sum_xy_q, sum_xx_q, sum_yy_q;
  logic                              lost_q;

  // Shared multiplier.
  logic [pcc_pkg::ProdW-1:0] mcand_q, prod_q;
  logic [pcc_pkg::MagW-1:0]  mplier_q;
  logic                      neg_q;

  // Formula terms, divider and square root.
  logic signed [pcc_pkg::WorkW-1:0] a_q, b_q, n_q;
  logic [pcc_pkg::LimW-1:0]         rem_q, dvs_q;
  logic [pcc_pkg::QuoBits-1:0]      quo_q;
  logic [pcc_pkg::SqrtW-1:0]        sq_num_q, sq_root_q, sq_bit_q, sq_trial;

  // Result register.
  logic signed [pcc_pkg::CoefW-1:0] coef_q;
  logic                             degen_q, ovf_q;
  logic [pcc_pkg::CountBits-1:0]    pcnt_q;

  logic signed [pcc_pkg::WorkW-1:0] op1, op2, cnt_w, prod_w, prod_s;
  logic [pcc_pkg::MagW-1:0]         mag1, mag2;
  logic [pcc_pkg::CoefW-1:0]        q_mag, coef_c;
  logic                             degen_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.s1_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.s1_load) begin
      s1_x_q  <= x_sample_i;
      s1_y_q  <= y_sample_i;
      s1_xy_q <= PB'(x_sample_i * y_sample_i);
      s1_xx_q <= PB'(x_sample_i * x_sample_i);
      s1_yy_q <= PB'(y_sample_i * y_sample_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xy_q <= '0;
      sum_xx_q <= '0;
      sum_yy_q <= '0;
      lost_q   <= 1'b0;
    end else if (cmd_i.result_load) begin
      cnt_q    <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xy_q <= '0;
      sum_xx_q <= '0;
      sum_yy_q <= '0;
      lost_q   <= 1'b0;
    end else if (s1_valid_q) begin
      if (cnt_q < pcc_pkg::CountBits'(pcc_pkg::MaxSamples)) begin
        cnt_q    <= cnt_q + 1'b1;
        sum_x_q  <= sum_x_q + pcc_pkg::SumW'(s1_x_q);
        sum_y_q  <= sum_y_q + pcc_pkg::SumW'(s1_y_q);
        sum_xy_q <= sum_xy_q + pcc_pkg::SqW'(s1_xy_q);
        sum_xx_q <= sum_xx_q + pcc_pkg::SqW'(s1_xx_q);
        sum_yy_q <= sum_yy_q + pcc_pkg::SqW'(s1_yy_q);
      end else begin
        lost_q <= 1'b1;
      end
    end
  end

  // Operand selection: signed operands, multiplied as magnitudes.
  always_comb begin
    cnt_w = pcc_pkg::WorkW'(signed'({1'b0, cnt_q}));
    unique case (cmd_i.op)
      pcc_pkg::OP_NXX: begin op1 = cnt_w; op2 = pcc_pkg::WorkW'(sum_xx_q); end
      pcc_pkg::OP_SXX: begin
        op1 = pcc_pkg::WorkW'(sum_x_q); op2 = pcc_pkg::WorkW'(sum_x_q);
      end
      pcc_pkg::OP_NYY: begin op1 = cnt_w; op2 = pcc_pkg::WorkW'(sum_yy_q); end
      pcc_pkg::OP_SYY: begin
        op1 = pcc_pkg::WorkW'(sum_y_q); op2 = pcc_pkg::WorkW'(sum_y_q);
      end
      pcc_pkg::OP_NXY: begin op1 = cnt_w; op2 = pcc_pkg::WorkW'(sum_xy_q); end
      pcc_pkg::OP_SXY: begin
        op1 = pcc_pkg::WorkW'(sum_x_q); op2 = pcc_pkg::WorkW'(sum_y_q);
      end
      pcc_pkg::OP_AB:  begin op1 = a_q; op2 = b_q; end
      pcc_pkg::OP_NN:  begin op1 = n_q; op2 = n_q; end
      default:         begin op1 = '0; op2 = '0; end
    endcase
    mag1 = op1[pcc_pkg::WorkW-1] ? pcc_pkg::MagW'(-op1) : pcc_pkg::MagW'(op1);
    mag2 = op2[pcc_pkg::WorkW-1] ? pcc_pkg::MagW'(-op2) : pcc_pkg::MagW'(op2);
    prod_w = signed'(prod_q[pcc_pkg::WorkW-1:0]);
    prod_s = neg_q ? -prod_w : prod_w;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      mplier_q <= mag1;
      mcand_q  <= pcc_pkg::ProdW'(mag2);
      prod_q   <= '0;
      neg_q    <= op1[pcc_pkg::WorkW-1] ^ op2[pcc_pkg::WorkW-1];
    end else if (cmd_i.mul_step) begin
      if (mplier_q[0]) begin
        prod_q <= prod_q + mcand_q;
      end
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  // Term registers; the divider works on the shifted squares in place.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_write) begin
      unique case (cmd_i.op)
        pcc_pkg::OP_NXX: a_q <= prod_s;
        pcc_pkg::OP_SXX: a_q <= a_q - prod_s;
        pcc_pkg::OP_NYY: b_q <= prod_s;
        pcc_pkg::OP_SYY: b_q <= b_q - prod_s;
        pcc_pkg::OP_NXY: n_q <= prod_s;
        pcc_pkg::OP_SXY: n_q <= n_q - prod_s;
        pcc_pkg::OP_AB:  dvs_q <= {prod_q, {pcc_pkg::DivShift{1'b0}}};
        pcc_pkg::OP_NN:  rem_q <= {prod_q, {pcc_pkg::DivShift{1'b0}}};
        default: ;
      endcase
    end else if (cmd_i.div_step) begin
      if (rem_q >= dvs_q) begin
        rem_q <= rem_q - dvs_q;
        quo_q <= {quo_q[pcc_pkg::QuoBits-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[pcc_pkg::QuoBits-2:0], 1'b0};
      end
      dvs_q <= dvs_q >> 1;
    end
  end

  assign sq_trial = sq_root_q + sq_bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      sq_num_q  <= pcc_pkg::SqrtW'(quo_q);
      sq_root_q <= '0;
      sq_bit_q  <= pcc_pkg::SqrtW'(1) << pcc_pkg::DivShift;
    end else if (cmd_i.sqrt_step) begin
      if (sq_num_q >= sq_trial) begin
        sq_num_q  <= sq_num_q - sq_trial;
        sq_root_q <= (sq_root_q >> 1) + sq_bit_q;
      end else begin
        sq_root_q <= sq_root_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
  end

  always_comb begin
    degen_c = (cnt_q < pcc_pkg::CountBits'(pcc_pkg::MinCount)) || (a_q == '0) ||
              (b_q == '0);
    q_mag   = sq_root_q[pcc_pkg::CoefW-1:0];
    if (n_q[pcc_pkg::WorkW-1]) begin
      coef_c = '0 - q_mag;
    end else if (q_mag[pcc_pkg::CoefW-1]) begin
      coef_c = {1'b0, {(pcc_pkg::CoefW - 1){1'b1}}};
    end else begin
      coef_c = q_mag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      coef_q  <= degen_c ? '0 : signed'(coef_c);
      degen_q <= degen_c;
      ovf_q   <= lost_q;
      pcnt_q  <= cnt_q;
    end
  end

  assign sts_o.mul_done = (mplier_q == '0);
  assign sts_o.degen    = degen_c;
  assign coefficient_o  = coef_q;
  assign degenerate_o   = degen_q;
  assign overflowed_o   = ovf_q;
  assign pair_count_o   = pcnt_q;

endmodule

>>> rtl/pcc_ctrl.sv
// ----------------------------------------------------------------------------
// pcc_ctrl: sequencer of the correlation block
// Runs the input handshake, steps the datapath through the multiplies,
// the division and the square root, and owns the result valid flag.
// ----------------------------------------------------------------------------
module pcc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          last_pair_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  pcc_pkg::sts_t sts_i,
  output pcc_pkg::cmd_t cmd_o
);

  pcc_pkg::state_e             state_q, state_d;
  pcc_pkg::op_e                op_q, op_d;
  logic [pcc_pkg::CtrW-1:0]    cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic                        accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcc_pkg::S_ACC;
      op_q        <= pcc_pkg::OP_NXX;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign accept = in_valid_i && (state_q == pcc_pkg::S_ACC);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = 1'b1;
    cmd_o       = '0;
    cmd_o.op    = op_q;
    unique case (state_q)
      pcc_pkg::S_ACC: begin
        in_stall_o     = 1'b0;
        cmd_o.s1_load  = accept;
        if (accept && last_pair_i) begin
          state_d = pcc_pkg::S_DRAIN;
        end
      end
      pcc_pkg::S_DRAIN: begin
        op_d    = pcc_pkg::OP_NXX;
        state_d = pcc_pkg::S_MLOAD;
      end
      pcc_pkg::S_MLOAD: begin
        cmd_o.mul_start = 1'b1;
        state_d         = pcc_pkg::S_MRUN;
      end
      pcc_pkg::S_MRUN: begin
        if (sts_i.mul_done) begin
          cmd_o.mul_write = 1'b1;
          if (op_q == pcc_pkg::OP_SXY) begin
            state_d = pcc_pkg::S_CHECK;
          end else if (op_q == pcc_pkg::OP_NN) begin
            cnt_d   = pcc_pkg::CtrW'(pcc_pkg::QuoBits - 1);
            state_d = pcc_pkg::S_DIV;
          end else begin
            op_d    = pcc_pkg::op_e'(op_q + 3'd1);
            state_d = pcc_pkg::S_MLOAD;
          end
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      pcc_pkg::S_CHECK: begin
        if (sts_i.degen) begin
          state_d = pcc_pkg::S_OUT;
        end else begin
          op_d    = pcc_pkg::OP_AB;
          state_d = pcc_pkg::S_MLOAD;
        end
      end
      pcc_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = pcc_pkg::S_SINIT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      pcc_pkg::S_SINIT: begin
        cmd_o.sqrt_init = 1'b1;
        cnt_d           = pcc_pkg::CtrW'(pcc_pkg::FracBits);
        state_d         = pcc_pkg::S_SQRT;
      end
      pcc_pkg::S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = pcc_pkg::S_OUT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      pcc_pkg::S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.result_load = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = pcc_pkg::S_ACC;
        end
      end
      default: state_d = pcc_pkg::S_ACC;
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  // A closing beat is followed by a stalled input until the result is built.
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_pair_i) |=> in_stall_o)
    else $error("input not stalled after closing beat");

  // A new result never overwrites one that is still held.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.result_load |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");

  // The divider counter stays within the quotient width.
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pcc_pkg::S_DIV) |-> (cnt_q < pcc_pkg::CtrW'(pcc_pkg::QuoBits)))
    else $error("divider step count out of range");

  // After the drain state comes the first multiply, with the input stalled.
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pcc_pkg::S_DRAIN) |=> (state_q == pcc_pkg::S_MLOAD && in_stall_o))
    else $error("drain not followed by first multiply");
`endif

endmodule

>>> rtl/pearson_correlation_top.sv
// ----------------------------------------------------------------------------
// pearson_correlation_top: streaming Pearson correlation coefficient
// Input beats carry one (x, y) pair each; a beat with last_pair_i set
// closes the data set. The output channel carries one result beat per set:
// the coefficient in Q1.15 (truncated toward zero, clamped), a degenerate
// flag for fewer than two pairs or zero variance, an overflow flag when
// pairs beyond capacity were dropped, and the number of pairs used.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low. Pairs are taken one per cycle while the input is not stalled.
// After the closing beat the input stalls while the finish runs: eight
// products on one shift-add multiplier (each one ends once the multiplier
// operand runs out of set bits), 31 divider steps and 16 square root
// steps; small sums finish sooner. A degenerate set skips the last
// two products, the division and the root. The result register then frees
// the accumulators, so a new set can stream in while the result waits.
// If the receiver stalls, the result holds, and a following set that
// closes before it is taken waits in its last step.
// Reset clears the sums, the count, the overflow flag and the result valid.
// ----------------------------------------------------------------------------
module pearson_correlation_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [pcc_pkg::SampleBits-1:0] x_sample_i,
  input  logic signed [pcc_pkg::SampleBits-1:0] y_sample_i,
  input  logic                                  last_pair_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [pcc_pkg::CoefW-1:0]      coefficient_o,
  output logic                                  degenerate_o,
  output logic                                  overflowed_o,
  output logic [pcc_pkg::CountBits-1:0]         pair_count_o
);

  // Commands from the sequencer and status back from the datapath.
  pcc_pkg::cmd_t cmd;
  pcc_pkg::sts_t sts;

  pcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_pair_i (last_pair_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pcc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .x_sample_i    (x_sample_i),
    .y_sample_i    (y_sample_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .coefficient_o (coefficient_o),
    .degenerate_o  (degenerate_o),
    .overflowed_o  (overflowed_o),
    .pair_count_o  (pair_count_o)
  );

endmodule

>>> test/pearson_correlation_top_test.sv
// ----------------------------------------------------------------------------
// pearson_correlation_top_test: self-checking bench for the correlation block
// Streams directed and random data sets of (x, y) pairs into the block. An
// exact wide-integer predictor keeps its own sums and computes the Q1.15
// coefficient for every closing beat. Result beats are checked in order.
// Both channels idle and stall at random in several phases, and one long
// receiver hold-off lets the block fill up and stall its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pearson_correlation_top_test;

  localparam int unsigned CycleLimit = 1500000;
  localparam int          DrainWait  = 700;
  localparam int          HoldOffLen = 3000;

  typedef struct packed {
    logic signed [pcc_pkg::SampleBits-1:0] x;
    logic signed [pcc_pkg::SampleBits-1:0] y;
    logic                                  last;
  } pair_t;

  typedef struct packed {
    logic signed [pcc_pkg::CoefW-1:0]  coef;
    logic                              degen;
    logic                              ovf;
    logic [pcc_pkg::CountBits-1:0]     cnt;
  } corr_t;

  logic                                  clk_i;
  logic                                  rst_ni;
  logic                                  in_valid_i;
  logic                                  in_stall_o;
  logic signed [pcc_pkg::SampleBits-1:0] x_sample_i;
  logic signed [pcc_pkg::SampleBits-1:0] y_sample_i;
  logic                                  last_pair_i;
  logic                                  out_valid_o;
  logic                                  out_stall_i;
  logic signed [pcc_pkg::CoefW-1:0]      coefficient_o;
  logic                                  degenerate_o;
  logic                                  overflowed_o;
  logic [pcc_pkg::CountBits-1:0]         pair_count_o;

  pearson_correlation_top i_dut (.*);

  // Pairs waiting to be sent and coefficients waiting to come back.
  pair_t pending_pairs[$];
  corr_t expected_corr[$];

  // Predictor state: exact running sums of the open data set.
  int          set_count;
  longint      sx, sy, sxy, sxx, syy;
  logic        set_lost;

  int unsigned pairs_taken;
  int unsigned cycles;
  int unsigned errors;
  int unsigned hold_left;
  logic        hold_done;
  int          send_idle_pct;
  int          recv_stall_pct;

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The idling phase follows the number of pairs taken so far: first a
  // stretch with no idling, then a lazy sender, then a lazy receiver,
  // then both idling now and then.
  always_comb begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    if (pairs_taken >= 1160) begin
      send_idle_pct  = 10;
      recv_stall_pct = 10;
    end else if (pairs_taken >= 1120) begin
      recv_stall_pct = 61;
    end else if (pairs_taken >= 1080) begin
      send_idle_pct = 61;
    end
  end

  // Exact coefficient of the open set. q is the largest value in 0..32768
  // with q^2 * A * B <= 2^30 * N^2; the sign of N is put back afterwards.
  function automatic corr_t correlate();
    logic signed [159:0] n, a, b, num;
    logic        [159:0] prod, lim, mid, lo, hi;
    logic                neg;
    corr_t               r;
    n   = 160'(set_count);
    a   = n * 160'(signed'(sxx)) - 160'(signed'(sx)) * 160'(signed'(sx));
    b   = n * 160'(signed'(syy)) - 160'(signed'(sy)) * 160'(signed'(sy));
    num = n * 160'(signed'(sxy)) - 160'(signed'(sx)) * 160'(signed'(sy));
    r.ovf = set_lost;
    r.cnt = set_count[pcc_pkg::CountBits-1:0];
    if (set_count < 2 || a == 0 || b == 0) begin
      r.coef  = '0;
      r.degen = 1'b1;
      return r;
    end
    r.degen = 1'b0;
    neg = num < 0;
    if (neg) num = -num;
    prod = a * b;
    lim  = (num * num) << 30;
    lo   = '0;
    hi   = 160'(32768);
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid * prod <= lim) lo = mid;
      else hi = mid - 1;
    end
    if (neg) r.coef = 16'(17'h10000 - lo[16:0]);
    else r.coef = (lo > 32767) ? 16'sd32767 : 16'(lo);
    return r;
  endfunction

  // Takes one accepted pair into the predictor.
  task automatic take_pair(pair_t p);
    longint vx, vy;
    vx = p.x;
    vy = p.y;
    if (set_count < pcc_pkg::MaxSamples) begin
      set_count++;
      sx  += vx;
      sy  += vy;
      sxy += vx * vy;
      sxx += vx * vx;
      syy += vy * vy;
    end else begin
      set_lost = 1'b1;
    end
    if (p.last) begin
      expected_corr = {expected_corr, correlate()};
      set_count = 0;
      {sx, sy, sxy, sxx, syy} = '0;
      set_lost = 1'b0;
    end
  endtask

  task automatic add_pair(int x, int y, bit last);
    pair_t p;
    p.x    = x[pcc_pkg::SampleBits-1:0];
    p.y    = y[pcc_pkg::SampleBits-1:0];
    p.last = last;
    pending_pairs = {pending_pairs, p};
  endtask

  // One random data set. The kind picks how x and y relate.
  task automatic add_set(int len, int kind);
    int x, y, k, c;
    c = $urandom_range(0, 65535) - 32768;
    for (k = 0; k < len; k++) begin
      x = $urandom_range(0, 65535) - 32768;
      case (kind)
        0: y = $urandom_range(0, 65535) - 32768;
        1: y = x / 2 + $urandom_range(0, 2000) - 1000;
        2: y = -x / 2 + $urandom_range(0, 200) - 100;
        3: begin
          x = $urandom_range(0, 15) - 8;
          y = $urandom_range(0, 15) - 8;
        end
        4: y = c;
        default: y = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      endcase
      add_pair(x, y, k == len - 1);
    end
  endtask

  // Driver: offers the next pending pair, holding it while stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      x_sample_i  <= '0;
      y_sample_i  <= '0;
      last_pair_i <= 1'b0;
      pairs_taken <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        take_pair({x_sample_i, y_sample_i, last_pair_i});
        pairs_taken <= pairs_taken + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          pair_t p;
          p = pending_pairs.pop_front();
          in_valid_i  <= 1'b1;
          x_sample_i  <= p.x;
          y_sample_i  <= p.y;
          last_pair_i <= p.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, once, while the sender keeps going.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && pairs_taken >= 300) begin
      hold_left <= HoldOffLen;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks every result beat against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_corr.size() == 0) begin
          $display("%0t: result beat with nothing expected: coef %0d", $time,
                   coefficient_o);
          errors++;
        end else begin
          corr_t e;
          e = expected_corr.pop_front();
          if (coefficient_o !== e.coef) begin
            $display("%0t: coefficient expected %0d actual %0d", $time, e.coef,
                     coefficient_o);
            errors++;
          end
          if (degenerate_o !== e.degen) begin
            $display("%0t: degenerate expected %0b actual %0b", $time, e.degen,
                     degenerate_o);
            errors++;
          end
          if (overflowed_o !== e.ovf) begin
            $display("%0t: overflowed expected %0b actual %0b", $time, e.ovf,
                     overflowed_o);
            errors++;
          end
          if (pair_count_o !== e.cnt) begin
            $display("%0t: pair_count expected %0d actual %0d", $time, e.cnt,
                     pair_count_o);
            errors++;
          end
        end
      end
      out_stall_i <= (hold_left > 1) || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Guard against a hung block.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int s;
    cycles    = 0;
    errors    = 0;
    set_count = 0;
    {sx, sy, sxy, sxx, syy} = '0;
    set_lost  = 1'b0;
    rst_ni    = 1'b0;

    // Directed sets: perfect positive correlation at the extremes (clamped
    // to just under one), perfect negative correlation, a single pair,
    // constant x, constant y, and the most negative samples.
    add_pair(-32768, -32768, 0);
    add_pair(32767, 32767, 0);
    add_pair(0, 0, 1);
    add_pair(32767, -32767, 0);
    add_pair(-32767, 32767, 0);
    add_pair(100, -100, 1);
    add_pair(-32768, 32767, 1);
    add_pair(5, 1, 0);
    add_pair(5, -7, 0);
    add_pair(5, 300, 1);
    add_pair(-1, 32767, 0);
    add_pair(2, 32767, 1);
    add_pair(-32768, 1, 0);
    add_pair(32767, -1, 0);
    add_pair(-32768, 0, 0);
    add_pair(1, 32767, 1);

    // First a set that runs past capacity so that pairs are dropped, then
    // random sets, mostly short and a few single pairs.
    for (s = 0; s < 24; s++) begin
      if (s == 0) add_set(pcc_pkg::MaxSamples + 2, 0);
      else if ($urandom_range(0, 9) == 0) add_set(1, $urandom_range(0, 5));
      else add_set($urandom_range(2, 12), $urandom_range(0, 5));
    end

    repeat (5) @(posedge clk_i);
    rst_ni = 1'b1;

    wait (pending_pairs.size() == 0 && !in_valid_i && expected_corr.size() == 0);
    repeat (DrainWait) @(posedge clk_i);

    if (errors == 0 && expected_corr.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
